@@ sv/b64d_pkg.sv @@
// shared types and constants of the base64 stream decoder
package b64d_pkg;

    // status codes on the final result of a string
    localparam logic [1:0] STATUS_OK      = 2'd0;
    localparam logic [1:0] STATUS_BAD_CHR = 2'd1;
    localparam logic [1:0] STATUS_BAD_LEN = 2'd2;
    localparam logic [1:0] STATUS_BAD_PAD = 2'd3;

    // configuration register indexes (byte address is 4 * index)
    localparam logic [1:0] REG_PADDING_ENABLE = 2'd0;
    localparam logic [1:0] REG_PAD_CHAR       = 2'd1;
    localparam logic [1:0] REG_CHAR_VALUE_62  = 2'd2;
    localparam logic [1:0] REG_CHAR_VALUE_63  = 2'd3;

    // register reset values
    localparam logic       RST_PADDING_ENABLE = 1'b1;
    localparam logic [7:0] RST_PAD_CHAR       = 8'd61;
    localparam logic [7:0] RST_CHAR_VALUE_62  = 8'd43;
    localparam logic [7:0] RST_CHAR_VALUE_63  = 8'd47;

    localparam int APB_ADDR_W = 4;
    localparam int APB_DATA_W = 32;
    localparam int RES_DEPTH  = 3;

    // one entry of the result buffer
    typedef struct packed {
        logic [7:0] data_byte;
        logic       byte_valid;
        logic       end_of_message;
        logic [1:0] status;
    } result_t;

    // alphabet lookup of one character
    typedef struct packed {
        logic [5:0] value;
        logic       bad;
    } sextet_lkp_t;

endpackage

@@ sv/b64d_char_if.sv @@
// character stream interface: one encoded character per transaction
interface b64d_char_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_in;
    logic       final_char;

    modport source (output valid, output char_in, output final_char, input ready);
    modport sink   (input valid, input char_in, input final_char, output ready);
endinterface

@@ sv/b64d_byte_if.sv @@
// byte stream interface: one decoded result per transaction
interface b64d_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       byte_valid;
    logic       end_of_message;
    logic [1:0] status;

    modport source (output valid, output data_byte, output byte_valid,
                    output end_of_message, output status, input ready);
    modport sink   (input valid, input data_byte, input byte_valid,
                    input end_of_message, input status, output ready);
endinterface

@@ sv/b64d_sextet_map.sv @@
// character to 6-bit value lookup with configurable alphabet tail
module b64d_sextet_map
(
    input  logic [7:0]          char_code,
    input  logic [7:0]          char_value_62,
    input  logic [7:0]          char_value_63,
    output b64d_pkg::sextet_lkp_t lkp
);

    localparam logic [7:0] UPPER_A = 8'h41;
    localparam logic [7:0] UPPER_Z = 8'h5A;
    localparam logic [7:0] LOWER_A = 8'h61;
    localparam logic [7:0] LOWER_Z = 8'h7A;
    localparam logic [7:0] DIGIT_0 = 8'h30;
    localparam logic [7:0] DIGIT_9 = 8'h39;

    logic [7:0] diff;

    always_comb
    begin
        diff      = 8'd0;
        lkp.value = 6'd0;
        lkp.bad   = 1'b0;
        if (char_code == char_value_62)
        begin
            lkp.value = 6'd62;
        end
        else if (char_code == char_value_63)
        begin
            lkp.value = 6'd63;
        end
        else if (char_code inside {[UPPER_A:UPPER_Z]})
        begin
            diff      = char_code - UPPER_A;
            lkp.value = diff[5:0];
        end
        else if (char_code inside {[LOWER_A:LOWER_Z]})
        begin
            diff      = char_code - LOWER_A + 8'd26;
            lkp.value = diff[5:0];
        end
        else if (char_code inside {[DIGIT_0:DIGIT_9]})
        begin
            diff      = char_code - DIGIT_0 + 8'd52;
            lkp.value = diff[5:0];
        end
        else
        begin
            // outside the alphabet: value reads as zero
            lkp.bad = 1'b1;
        end
    end

endmodule

@@ sv/base64_stream_decoder_unit.sv @@
// top level of the streaming base64 decoder with apb configuration port
// output: results of a character are offered in the cycle after its transaction
// throughput: one character per cycle while the output port is ready; a completed
//   group holds the input while its three bytes drain through the single output port
// reset: rst_n is asynchronous and active low; it clears the stream state and the
//   result buffer, and loads the register defaults ('=', '+', '/', padding on)
module base64_stream_decoder_unit
(
    input  logic                            clk,
    input  logic                            rst_n,
    // apb configuration port
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [b64d_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [b64d_pkg::APB_DATA_W-1:0] pwdata,
    output logic [b64d_pkg::APB_DATA_W-1:0] prdata,
    output logic                            pready,
    // streams
    b64d_char_if.sink                       char_stream,
    b64d_byte_if.source                     byte_stream
);

    // ------------------------------------------------------------------
    // configuration registers
    // ------------------------------------------------------------------
    logic       padding_enable_reg;
    logic [7:0] pad_char_reg;
    logic [7:0] char_value_62_reg;
    logic [7:0] char_value_63_reg;
    logic       cfg_write;

    assign pready    = 1'b1;
    assign cfg_write = psel & penable & pwrite & pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            padding_enable_reg <= b64d_pkg::RST_PADDING_ENABLE;
            pad_char_reg       <= b64d_pkg::RST_PAD_CHAR;
            char_value_62_reg  <= b64d_pkg::RST_CHAR_VALUE_62;
            char_value_63_reg  <= b64d_pkg::RST_CHAR_VALUE_63;
        end
        else if (cfg_write)
        begin
            case (paddr[3:2])
                b64d_pkg::REG_PADDING_ENABLE: padding_enable_reg <= pwdata[0];
                b64d_pkg::REG_PAD_CHAR:       pad_char_reg       <= pwdata[7:0];
                b64d_pkg::REG_CHAR_VALUE_62:  char_value_62_reg  <= pwdata[7:0];
                b64d_pkg::REG_CHAR_VALUE_63:  char_value_63_reg  <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    // read back, zero extended
    always_comb
    begin
        case (paddr[3:2])
            b64d_pkg::REG_PADDING_ENABLE: prdata = {31'd0, padding_enable_reg};
            b64d_pkg::REG_PAD_CHAR:       prdata = {24'd0, pad_char_reg};
            b64d_pkg::REG_CHAR_VALUE_62:  prdata = {24'd0, char_value_62_reg};
            b64d_pkg::REG_CHAR_VALUE_63:  prdata = {24'd0, char_value_63_reg};
            default:                      prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // stream state: pending sextets, group position, pads, length, error
    // ------------------------------------------------------------------
    logic [17:0] sextet_buf_reg, sextet_buf_next;
    logic [1:0]  group_pos_reg,  group_pos_next;
    logic [1:0]  pad_seen_reg,   pad_seen_next;
    logic [1:0]  length_reg,     length_next;
    logic [1:0]  error_reg,      error_next;

    // result buffer: entry 0 is what the output port offers
    b64d_pkg::result_t res_reg  [b64d_pkg::RES_DEPTH];
    b64d_pkg::result_t res_next [b64d_pkg::RES_DEPTH];
    b64d_pkg::result_t res_new  [b64d_pkg::RES_DEPTH];
    logic [1:0]        cnt_reg, cnt_next;
    logic [1:0]        res_new_cnt;

    logic char_accept;
    logic res_pop;

    // output side drains one result per transaction
    assign res_pop = (cnt_reg != 2'd0) & byte_stream.ready;

    // a new character is taken once the buffer is empty or about to be
    assign char_stream.ready = (cnt_reg == 2'd0) | ((cnt_reg == 2'd1) & byte_stream.ready);
    assign char_accept       = char_stream.valid & char_stream.ready;

    // ------------------------------------------------------------------
    // decode of one character
    // ------------------------------------------------------------------
    b64d_pkg::sextet_lkp_t lkp;

    b64d_sextet_map u_sextet_map
    (
        .char_code     (char_stream.char_in),
        .char_value_62 (char_value_62_reg),
        .char_value_63 (char_value_63_reg),
        .lkp           (lkp)
    );

    logic        is_pad;
    logic [5:0]  sextet;
    logic [17:0] buf_w;
    logic [1:0]  gpos_w;
    logic [1:0]  pad_w;
    logic [1:0]  len_w;
    logic [1:0]  err_w;
    logic [23:0] word;
    logic [7:0]  byte_w [b64d_pkg::RES_DEPTH];
    logic [1:0]  nb;
    logic        len_bad;
    logic [1:0]  status_w;

    always_comb
    begin
        is_pad = padding_enable_reg & (char_stream.char_in == pad_char_reg);
        sextet = lkp.bad ? 6'd0 : lkp.value;
        buf_w  = sextet_buf_reg;
        gpos_w = group_pos_reg;
        pad_w  = pad_seen_reg;
        len_w  = length_reg + 2'd1;
        err_w  = error_reg;
        word   = {sextet_buf_reg, sextet};
        nb     = 2'd0;
        for (int i = 0; i < b64d_pkg::RES_DEPTH; i++)
        begin
            byte_w[i] = 8'd0;
        end

        if (is_pad)
        begin
            // a third pad counts as a bad character
            if (pad_seen_reg >= 2'd2)
            begin
                if (err_w == b64d_pkg::STATUS_OK)
                begin
                    err_w = b64d_pkg::STATUS_BAD_CHR;
                end
            end
            else
            begin
                pad_w = pad_seen_reg + 2'd1;
            end
        end
        else
        begin
            // data after a pad is a padding error and is not accumulated
            if ((pad_seen_reg != 2'd0) && (err_w == b64d_pkg::STATUS_OK))
            begin
                err_w = b64d_pkg::STATUS_BAD_PAD;
            end
            if (lkp.bad && (err_w == b64d_pkg::STATUS_OK))
            begin
                err_w = b64d_pkg::STATUS_BAD_CHR;
            end
            if (pad_seen_reg == 2'd0)
            begin
                if (group_pos_reg == 2'd3)
                begin
                    // fourth sextet closes the group: three bytes at once
                    byte_w[0] = word[23:16];
                    byte_w[1] = word[15:8];
                    byte_w[2] = word[7:0];
                    nb        = 2'd3;
                    buf_w     = 18'd0;
                    gpos_w    = 2'd0;
                end
                else
                begin
                    buf_w  = word[17:0];
                    gpos_w = group_pos_reg + 2'd1;
                end
            end
        end

        // final character: length check and flush of a partial group
        len_bad  = padding_enable_reg ? (len_w != 2'd0) : (len_w == 2'd1);
        status_w = len_bad ? b64d_pkg::STATUS_BAD_LEN : err_w;

        for (int i = 0; i < b64d_pkg::RES_DEPTH; i++)
        begin
            res_new[i] = '0;
        end
        res_new_cnt = 2'd0;

        if (!char_stream.final_char)
        begin
            // once an error is known no further bytes leave
            if (err_w == b64d_pkg::STATUS_OK)
            begin
                res_new_cnt = nb;
                for (int i = 0; i < b64d_pkg::RES_DEPTH; i++)
                begin
                    res_new[i].data_byte  = byte_w[i];
                    res_new[i].byte_valid = 1'b1;
                end
            end
        end
        else
        begin
            if (status_w != b64d_pkg::STATUS_OK)
            begin
                nb = 2'd0;
            end
            else if (gpos_w == 2'd2)
            begin
                byte_w[0] = buf_w[11:4];
                nb        = 2'd1;
            end
            else if (gpos_w == 2'd3)
            begin
                byte_w[0] = buf_w[17:10];
                byte_w[1] = buf_w[9:2];
                nb        = 2'd2;
            end

            if (nb == 2'd0)
            begin
                // lone end marker carrying the status
                res_new[0].end_of_message = 1'b1;
                res_new[0].status         = status_w;
                res_new_cnt               = 2'd1;
            end
            else
            begin
                res_new_cnt = nb;
                for (int i = 0; i < b64d_pkg::RES_DEPTH; i++)
                begin
                    res_new[i].data_byte      = byte_w[i];
                    res_new[i].byte_valid     = 1'b1;
                    res_new[i].end_of_message = (2'(i) == nb - 2'd1);
                    res_new[i].status         = (2'(i) == nb - 2'd1) ? status_w
                                                                     : b64d_pkg::STATUS_OK;
                end
            end
        end
    end

    // next state of the stream; a final character returns everything to zero
    always_comb
    begin
        sextet_buf_next = sextet_buf_reg;
        group_pos_next  = group_pos_reg;
        pad_seen_next   = pad_seen_reg;
        length_next     = length_reg;
        error_next      = error_reg;
        if (char_accept)
        begin
            if (char_stream.final_char)
            begin
                sextet_buf_next = 18'd0;
                group_pos_next  = 2'd0;
                pad_seen_next   = 2'd0;
                length_next     = 2'd0;
                error_next      = b64d_pkg::STATUS_OK;
            end
            else
            begin
                sextet_buf_next = buf_w;
                group_pos_next  = gpos_w;
                pad_seen_next   = pad_w;
                length_next     = len_w;
                error_next      = err_w;
            end
        end
    end

    // result buffer: load on a new character, otherwise shift on each pop
    always_comb
    begin
        res_next = res_reg;
        cnt_next = cnt_reg;
        if (char_accept)
        begin
            res_next = res_new;
            cnt_next = res_new_cnt;
        end
        else if (res_pop)
        begin
            res_next[0] = res_reg[1];
            res_next[1] = res_reg[2];
            cnt_next    = cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sextet_buf_reg <= 18'd0;
            group_pos_reg  <= 2'd0;
            pad_seen_reg   <= 2'd0;
            length_reg     <= 2'd0;
            error_reg      <= b64d_pkg::STATUS_OK;
            cnt_reg        <= 2'd0;
        end
        else
        begin
            sextet_buf_reg <= sextet_buf_next;
            group_pos_reg  <= group_pos_next;
            pad_seen_reg   <= pad_seen_next;
            length_reg     <= length_next;
            error_reg      <= error_next;
            cnt_reg        <= cnt_next;
        end
    end

    // payload of the result buffer needs no reset
    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
    end

    // output port offers the head of the buffer
    assign byte_stream.valid          = (cnt_reg != 2'd0);
    assign byte_stream.data_byte      = res_reg[0].data_byte;
    assign byte_stream.byte_valid     = res_reg[0].byte_valid;
    assign byte_stream.end_of_message = res_reg[0].end_of_message;
    assign byte_stream.status         = res_reg[0].status;

`ifndef SYNTHESIS
    // a result without a byte only ever marks the end of a string
    a_empty_is_end: assert property (@(posedge clk) disable iff (!rst_n)
        (byte_stream.valid && !byte_stream.byte_valid) |-> byte_stream.end_of_message)
        else $error("result without byte is not an end marker");

    // a non-zero status only travels on the end marker
    a_status_on_end: assert property (@(posedge clk) disable iff (!rst_n)
        (byte_stream.valid && (byte_stream.status != b64d_pkg::STATUS_OK))
            |-> byte_stream.end_of_message)
        else $error("status reported before end of message");

    // no character is taken while two or more results are still pending
    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        (cnt_reg >= 2'd2) |-> !char_stream.ready)
        else $error("input taken with result buffer still full");

    // stream state is clean after the final character
    a_final_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (char_accept && char_stream.final_char) |=>
            ((group_pos_reg == 2'd0) && (pad_seen_reg == 2'd0) &&
             (length_reg == 2'd0) && (error_reg == b64d_pkg::STATUS_OK)))
        else $error("stream state not cleared after final character");
`endif

endmodule

@@ tb/b64d_stream_checker.sv @@
// checker of the base64 stream decoder: predicts decoded bytes and compares them
`timescale 1ns / 100ps
module b64d_stream_checker
(
    input  logic                            clk,
    input  logic                            rst_n,
    b64d_char_if                            char_mon,
    b64d_byte_if                            byte_mon,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [b64d_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [b64d_pkg::APB_DATA_W-1:0] pwdata,
    input  logic                            pready,
    output int                              fail_count,
    output int                              pending
);
    import b64d_pkg::*;

    // configuration as last written on the apb port
    logic        pad_on;
    logic [7:0]  pad_code;
    logic [7:0]  code_62;
    logic [7:0]  code_63;

    // decoder stream state
    logic [17:0] sextet_buf;
    logic [1:0]  group_fill;
    logic [1:0]  pads_seen;
    logic [1:0]  length_mod4;
    logic [1:0]  first_error;

    result_t     due_bytes[$];
    result_t     want;

    function automatic sextet_lkp_t lookup_sextet(input logic [7:0] c);
        sextet_lkp_t lk;
        lk.bad = 1'b0;
        if (c == code_62)
            lk.value = 6'd62;
        else if (c == code_63)
            lk.value = 6'd63;
        else if (c >= "A" && c <= "Z")
            lk.value = 6'(c - "A");
        else if (c >= "a" && c <= "z")
            lk.value = 6'(c - "a" + 8'd26);
        else if (c >= "0" && c <= "9")
            lk.value = 6'(c - "0" + 8'd52);
        else
        begin
            lk.value = 6'd0;
            lk.bad   = 1'b1;
        end
        return lk;
    endfunction

    task automatic flag_error(input logic [1:0] code);
        if (first_error == STATUS_OK)
            first_error = code;
    endtask

    task automatic queue_byte(input logic [7:0] b, input logic bv, input logic eom,
                              input logic [1:0] st);
        result_t r;
        r.data_byte      = b;
        r.byte_valid     = bv;
        r.end_of_message = eom;
        r.status         = st;
        due_bytes.push_back(r);
    endtask

    task automatic clear_stream();
        sextet_buf  = '0;
        group_fill  = '0;
        pads_seen   = '0;
        length_mod4 = '0;
        first_error = STATUS_OK;
    endtask

    // one character in, zero to three decoded results out
    task automatic decode_char(input logic [7:0] c, input logic fin);
        sextet_lkp_t lk;
        logic [23:0] word;
        logic [7:0]  out_byte [3];
        logic [1:0]  st;
        logic        len_bad;
        int          nb;
        nb = 0;
        length_mod4 = length_mod4 + 2'd1;
        if (pad_on && c == pad_code)
        begin
            if (pads_seen >= 2)
                flag_error(STATUS_BAD_CHR);
            else
                pads_seen = pads_seen + 2'd1;
        end
        else
        begin
            lk = lookup_sextet(c);
            if (pads_seen != 0)
                flag_error(STATUS_BAD_PAD);
            if (lk.bad)
                flag_error(STATUS_BAD_CHR);
            // data after a pad is not accumulated
            if (pads_seen == 0)
            begin
                if (group_fill == 2'd3)
                begin
                    word        = {sextet_buf, lk.value};
                    out_byte[0] = word[23:16];
                    out_byte[1] = word[15:8];
                    out_byte[2] = word[7:0];
                    nb          = 3;
                    sextet_buf  = '0;
                    group_fill  = '0;
                end
                else
                begin
                    sextet_buf = {sextet_buf[11:0], lk.value};
                    group_fill = group_fill + 2'd1;
                end
            end
        end

        if (!fin)
        begin
            if (first_error != STATUS_OK)
                nb = 0;
            for (int i = 0; i < nb; i++)
                queue_byte(out_byte[i], 1'b1, 1'b0, STATUS_OK);
        end
        else
        begin
            len_bad = pad_on ? (length_mod4 != 2'd0) : (length_mod4 == 2'd1);
            st = len_bad ? STATUS_BAD_LEN : first_error;
            if (st != STATUS_OK)
                nb = 0;
            else if (group_fill == 2'd2)
            begin
                out_byte[0] = sextet_buf[11:4];
                nb = 1;
            end
            else if (group_fill == 2'd3)
            begin
                out_byte[0] = sextet_buf[17:10];
                out_byte[1] = sextet_buf[9:2];
                nb = 2;
            end
            if (nb == 0)
                queue_byte(8'd0, 1'b0, 1'b1, st);
            else
                for (int i = 0; i < nb; i++)
                    queue_byte(out_byte[i], 1'b1, i == nb - 1, (i == nb - 1) ? st : STATUS_OK);
            clear_stream();
        end
    endtask

    task automatic check_field(input string what, input logic [7:0] exp_val,
                               input logic [7:0] got_val);
        if (got_val !== exp_val)
        begin
            $display("%0t: %s mismatch, expected %0h actual %0h", $time, what, exp_val, got_val);
            fail_count++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pad_on     = RST_PADDING_ENABLE;
            pad_code   = RST_PAD_CHAR;
            code_62    = RST_CHAR_VALUE_62;
            code_63    = RST_CHAR_VALUE_63;
            clear_stream();
            due_bytes.delete();
            fail_count = 0;
        end
        else
        begin
            // results come from a register after their character, so check first
            if (byte_mon.valid && byte_mon.ready)
            begin
                if (due_bytes.size() == 0)
                begin
                    $display("%0t: unexpected result, expected none actual %0h/%0b/%0b/%0d",
                             $time, byte_mon.data_byte, byte_mon.byte_valid,
                             byte_mon.end_of_message, byte_mon.status);
                    fail_count++;
                end
                else
                begin
                    want = due_bytes.pop_front();
                    check_field("data_byte", want.data_byte, byte_mon.data_byte);
                    check_field("byte_valid", 8'(want.byte_valid), 8'(byte_mon.byte_valid));
                    check_field("end_of_message", 8'(want.end_of_message),
                                8'(byte_mon.end_of_message));
                    check_field("status", 8'(want.status), 8'(byte_mon.status));
                end
            end
            if (char_mon.valid && char_mon.ready)
                decode_char(char_mon.char_in, char_mon.final_char);
            if (psel && penable && pwrite && pready)
            begin
                case (paddr[3:2])
                    REG_PADDING_ENABLE: pad_on   = pwdata[0];
                    REG_PAD_CHAR:       pad_code = pwdata[7:0];
                    REG_CHAR_VALUE_62:  code_62  = pwdata[7:0];
                    REG_CHAR_VALUE_63:  code_63  = pwdata[7:0];
                    default: ;
                endcase
            end
        end
        pending = due_bytes.size();
    end

endmodule

@@ tb/base64_stream_decoder_unit_test.sv @@
// testbench top of the base64 stream decoder: stimulus, watchdog and verdict
`timescale 1ns / 100ps
module base64_stream_decoder_unit_test;
    import b64d_pkg::*;

    // cycles without any transaction before the run is abandoned
    localparam int STALL_LIMIT   = 2000;
    // results appear in the cycle after their character; a margin follows the drain
    localparam int SETTLE_CYCLES = 4;
    // characters per random phase
    localparam int PHASE_CHARS   = 14;

    // how a random string is shaped
    typedef enum int {
        SHAPE_CLEAN   = 0,
        SHAPE_NOISE   = 1,
        SHAPE_CORRUPT = 2,
        SHAPE_RESIZE  = 3
    } shape_t;

    logic                  clk     = 1'b0;
    logic                  rst_n   = 1'b0;
    logic                  psel    = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite  = 1'b0;
    logic [APB_ADDR_W-1:0] paddr   = '0;
    logic [APB_DATA_W-1:0] pwdata  = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;
    int                    fail_count;
    int                    pending;

    b64d_char_if char_stream();
    b64d_byte_if byte_stream();

    // stimulus-side copy of the register values, used to build legal strings
    logic                  cfg_pad_on;
    logic [7:0]            cfg_pad;
    logic [7:0]            cfg_62;
    logic [7:0]            cfg_63;

    // the encoded string being sent
    logic [7:0]            enc_chars[$];
    // transactions left in the current sender burst
    int                    burst_left = 0;
    // cycles since the last transaction of any kind
    int                    idle_run   = 0;

    always #5 clk = ~clk;

    base64_stream_decoder_unit i_dut
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .char_stream (char_stream),
        .byte_stream (byte_stream)
    );

    b64d_stream_checker i_checker
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .char_mon   (char_stream),
        .byte_mon   (byte_stream),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .pready     (pready),
        .fail_count (fail_count),
        .pending    (pending)
    );

    // watchdog: a hung handshake or a lost result ends the run here
    always @(posedge clk)
    begin
        if ((char_stream.valid && char_stream.ready) ||
            (byte_stream.valid && byte_stream.ready) || (psel && penable))
            idle_run = 0;
        else
        begin
            idle_run++;
            if (idle_run >= STALL_LIMIT)
            begin
                $display("FAILURE");
                $finish;
            end
        end
    end

    // receiver back-pressure: a random pattern, from always ready through mostly
    // ready and periodic gaps to mostly stalled
    initial
    begin
        int cyc;
        int mode;
        cyc  = 0;
        mode = 0;
        byte_stream.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (cyc % 50 == 0)
                mode = $urandom_range(0, 3);
            case (mode)
                0:       byte_stream.ready = 1'b1;
                1:       byte_stream.ready = ($urandom_range(0, 3) != 0);
                2:       byte_stream.ready = ($urandom_range(0, 3) == 0);
                default: byte_stream.ready = (cyc % 5 != 0);
            endcase
            cyc++;
        end
    end

    // apb write: setup cycle, then access cycle until pready
    task automatic write_cfg(input logic [1:0] idx, input logic [7:0] value);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = APB_ADDR_W'({idx, 2'b00});
        pwdata  = APB_DATA_W'(value);
        @(negedge clk);
        penable = 1'b1;
        do @(posedge clk); while (!pready);
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
        case (idx)
            REG_PADDING_ENABLE: cfg_pad_on = value[0];
            REG_PAD_CHAR:       cfg_pad    = value;
            REG_CHAR_VALUE_62:  cfg_62     = value;
            REG_CHAR_VALUE_63:  cfg_63     = value;
            default: ;
        endcase
    endtask

    task automatic apply_config(input logic pad_on, input logic [7:0] pad,
                                input logic [7:0] c62, input logic [7:0] c63);
        write_cfg(REG_PADDING_ENABLE, {7'd0, pad_on});
        write_cfg(REG_PAD_CHAR, pad);
        write_cfg(REG_CHAR_VALUE_62, c62);
        write_cfg(REG_CHAR_VALUE_63, c63);
    endtask

    // one character transaction; valid stays high while the burst lasts
    task automatic send_char(input logic [7:0] c, input logic fin);
        if (burst_left == 0)
        begin
            char_stream.valid = 1'b0;
            repeat ($urandom_range(1, 5)) @(negedge clk);
            burst_left = ($urandom_range(0, 3) == 0) ? 40 : $urandom_range(1, 10);
        end
        burst_left--;
        char_stream.valid      = 1'b1;
        char_stream.char_in    = c;
        char_stream.final_char = fin;
        do @(posedge clk); while (!char_stream.ready);
        @(negedge clk);
    endtask

    // send the whole string, flagging its last character
    task automatic send_text();
        for (int i = 0; i < enc_chars.size(); i++)
            send_char(enc_chars[i], i == enc_chars.size() - 1);
    endtask

    task automatic load_text(input string s);
        enc_chars.delete();
        for (int i = 0; i < s.len(); i++)
            enc_chars.push_back(s[i]);
    endtask

    // hold the sender off until every outstanding result has drained
    task automatic settle();
        char_stream.valid = 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // character for a 6-bit value under the current alphabet
    function automatic logic [7:0] alpha_char(input int idx);
        if (idx < 26)
            return 8'("A" + idx);
        else if (idx < 52)
            return 8'("a" + idx - 26);
        else if (idx < 62)
            return 8'("0" + idx - 52);
        else if (idx == 62)
            return cfg_62;
        else
            return cfg_63;
    endfunction

    // mostly well-formed strings with random content, the rest noise or broken ones
    task automatic run_random(input int chars);
        int     sent;
        int     groups;
        int     tail;
        int     pick;
        int     pos;
        shape_t shape;
        sent = 0;
        while (sent < chars)
        begin
            pick  = $urandom_range(0, 9);
            shape = (pick < 7) ? SHAPE_CLEAN : shape_t'(pick - 6);
            // mostly short strings, now and then a longer one
            groups = ($urandom_range(0, 7) == 0) ? $urandom_range(4, 6) : $urandom_range(0, 2);
            tail   = $urandom_range(0, 2);
            if (tail != 0)
                tail++;
            if (groups == 0 && tail == 0)
                groups = 1;
            enc_chars.delete();
            repeat (groups * 4 + tail)
                enc_chars.push_back(alpha_char($urandom_range(0, 63)));
            if (cfg_pad_on && tail != 0)
                repeat (4 - tail) enc_chars.push_back(cfg_pad);
            case (shape)
                SHAPE_NOISE:
                begin
                    enc_chars.delete();
                    repeat ($urandom_range(1, 8))
                        enc_chars.push_back(8'($urandom_range(0, 255)));
                end
                SHAPE_CORRUPT:
                begin
                    pos = $urandom_range(0, enc_chars.size() - 1);
                    enc_chars[pos] = 8'($urandom_range(0, 255));
                end
                SHAPE_RESIZE:
                begin
                    // short by one, an extra pad, or one data character too many
                    case ($urandom_range(0, 2))
                        0:
                            if (enc_chars.size() > 1)
                                void'(enc_chars.pop_back());
                        1:       enc_chars.push_back(cfg_pad);
                        default: enc_chars.push_back(alpha_char($urandom_range(0, 63)));
                    endcase
                end
                default: ;
            endcase
            send_text();
            sent += enc_chars.size();
            // now and then the sender waits for the decoder to drain completely
            if ($urandom_range(0, 7) == 0)
                settle();
        end
    endtask

    initial
    begin
        char_stream.valid      = 1'b0;
        char_stream.char_in    = 8'd0;
        char_stream.final_char = 1'b0;
        repeat (6) @(negedge clk);
        rst_n      = 1'b1;
        cfg_pad_on = RST_PADDING_ENABLE;
        cfg_pad    = RST_PAD_CHAR;
        cfg_62     = RST_CHAR_VALUE_62;
        cfg_63     = RST_CHAR_VALUE_63;
        @(negedge clk);

        // directed part under the reset alphabet
        // full group on the last character gives three bytes
        load_text("TWFu");
        send_text();
        // two pads leave a single byte
        load_text("TQ==");
        send_text();
        // values 62 and 63 with one pad, two bytes
        load_text("+/8=");
        send_text();
        // all-zero and all-one codes are outside the alphabet
        enc_chars = '{8'h00, 8'hFF, "A", "A"};
        send_text();
        // a lone character is always a length error
        load_text("A");
        send_text();
        // data after a pad
        load_text("TQ=A");
        send_text();
        // a third pad counts as a bad character
        load_text("A===");
        send_text();
        settle();

        // random phases under several alphabets and padding modes
        run_random(PHASE_CHARS);
        settle();
        // url-safe alphabet, unpadded, pad code zero
        apply_config(1'b0, 8'h00, "-", "_");
        run_random(PHASE_CHARS);
        settle();
        // padded, pad code clashes with value 63 and wins over it
        apply_config(1'b1, 8'hFF, 8'h00, 8'hFF);
        run_random(PHASE_CHARS);
        settle();
        // unpadded, value 62 and value 63 share a code
        apply_config(1'b0, 8'h00, 8'hFF, 8'hFF);
        run_random(PHASE_CHARS);
        settle();
        // arbitrary codes, which may shadow letters or digits
        apply_config(1'b1, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                     8'($urandom_range(0, 255)));
        run_random(PHASE_CHARS);
        settle();
        // back to the standard alphabet
        apply_config(RST_PADDING_ENABLE, RST_PAD_CHAR, RST_CHAR_VALUE_62, RST_CHAR_VALUE_63);
        run_random(PHASE_CHARS);
        settle();

        if (fail_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
